>>> sv/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define AST_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition");
`else
`define AST_PROP(lbl, clk, rst, prop)
`define AST_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> sv/fap_pkg.sv
`default_nettype none
package fap_pkg;

   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_SUB = 4'd1;
   localparam logic [3:0] OP_MUL = 4'd2;
   localparam logic [3:0] OP_DIV = 4'd3;
   localparam logic [3:0] OP_MIN = 4'd4;
   localparam logic [3:0] OP_MAX = 4'd5;
   localparam logic [3:0] OP_INC = 4'd6;
   localparam logic [3:0] OP_DEC = 4'd7;
   localparam logic [3:0] OP_I2F = 4'd8;
   localparam logic [3:0] OP_F2I = 4'd9;

   localparam logic signed [47:0] S32_MAX = 48'sd2147483647;
   localparam logic signed [47:0] S32_MIN = -48'sd2147483648;

   typedef struct packed {
      logic [31:0] result;
      logic        ov;
   } res_type;

   // Side data that travels with each beat through the divider chain.
   typedef struct packed {
      logic [3:0]  op;
      logic [31:0] result;
      logic        ov;
      logic        less;
      logic        equal;
      logic        greater;
      logic        dz;
      logic        neg;
   } side_type;

   function automatic res_type sat48(input logic signed [47:0] v);
      res_type r;
      r.ov = 1'b0;
      r.result = v[31:0];
      if (v > S32_MAX) begin
         r.ov = 1'b1;
         r.result = S32_MAX[31:0];
      end else if (v < S32_MIN) begin
         r.ov = 1'b1;
         r.result = S32_MIN[31:0];
      end
      return r;
   endfunction

   function automatic res_type sign_mag(input logic neg, input logic [63:0] mag);
      res_type r;
      r.ov = 1'b0;
      if (neg) begin
         if (mag > 64'd2147483648) begin
            r.ov = 1'b1;
            r.result = 32'h8000_0000;
         end else begin
            r.result = -mag[31:0];
         end
      end else begin
         if (mag > 64'd2147483647) begin
            r.ov = 1'b1;
            r.result = 32'h7fff_ffff;
         end else begin
            r.result = mag[31:0];
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> sv/fixed_point_alu.sv
// A request passes the input stage, the operand stage, the divider chain and the output register.
// Throughput: one beat per cycle; busy stays low, since every stage advances each cycle.
// Most of the latency comes from the divider chain, one cell per quotient bit (FRAC_BITS + 33).
// Synchronous active-high reset clears all valid bits; no result strobes after it until a new start.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
`include "assert_macros.svh"
module fixed_point_alu
   import fap_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [3:0]         req_type,
   input  wire logic signed [31:0] req_operand_a,
   input  wire logic signed [31:0] req_operand_b,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_result,
   output logic                    rsp_a_less,
   output logic                    rsp_a_equal,
   output logic                    rsp_a_greater,
   output logic                    rsp_overflow,
   output logic                    rsp_div_by_zero
);

   localparam int NW  = 33 + FRAC_BITS;
   localparam int LAT = NW + 3;
   localparam logic [63:0] RND  = (64'd1 << FRAC_BITS) >> 1;
   localparam logic signed [32:0] BIAS = 33'sd1 <<< FRAC_BITS;

   // Input stage.
   logic               v1_ff;
   logic [3:0]         op1_ff;
   logic signed [31:0] a1_ff, b1_ff;

   // Operand stage.
   logic               v2_ff;
   side_type           side2_ff, side2_in;
   logic signed [63:0] p2_ff;
   logic [NW-1:0]      nq2_ff, nq2_in;
   logic [31:0]        den2_ff;

   // Divider chain taps.
   logic               cv   [0:NW];
   side_type           cside[0:NW];
   logic [NW-1:0]      cnq  [0:NW];
   logic [31:0]        crem [0:NW];
   logic [31:0]        cden [0:NW];

   logic [31:0]        mag_a, mag_b;
   logic signed [32:0] f2i_t;
   res_type            simple_r, mul_r, div_r;
   logic [63:0]        mag_p, mul_m;
   logic [NW:0]        q_round;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_result_ff;
   logic               rsp_less_ff, rsp_equal_ff, rsp_greater_ff, rsp_ov_ff, rsp_dz_ff;
   logic [31:0]        fin_result;
   logic               fin_ov;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      op1_ff <= req_type;
      a1_ff  <= req_operand_a;
      b1_ff  <= req_operand_b;
   end

   always_comb begin
      mag_a = a1_ff[31] ? -a1_ff : a1_ff;
      mag_b = b1_ff[31] ? -b1_ff : b1_ff;
      f2i_t = a1_ff[31] ? (33'(a1_ff) + BIAS - 33'sd1) : 33'(a1_ff);
      case (op1_ff)
         OP_ADD: simple_r = sat48(48'(a1_ff) + 48'(b1_ff));
         OP_SUB: simple_r = sat48(48'(a1_ff) - 48'(b1_ff));
         OP_MIN: simple_r = '{result: (a1_ff < b1_ff) ? a1_ff : b1_ff, ov: 1'b0};
         OP_MAX: simple_r = '{result: (a1_ff > b1_ff) ? a1_ff : b1_ff, ov: 1'b0};
         OP_INC: simple_r = sat48(48'(a1_ff) + 48'sd1);
         OP_DEC: simple_r = sat48(48'(a1_ff) - 48'sd1);
         OP_I2F: simple_r = sat48(48'(a1_ff) <<< FRAC_BITS);
         OP_F2I: simple_r = '{result: 32'(f2i_t >>> FRAC_BITS), ov: 1'b0};
         default: simple_r = '{result: 32'd0, ov: 1'b0};
      endcase
      side2_in.op      = op1_ff;
      side2_in.result  = simple_r.result;
      side2_in.ov      = simple_r.ov;
      side2_in.less    = a1_ff < b1_ff;
      side2_in.equal   = a1_ff == b1_ff;
      side2_in.greater = a1_ff > b1_ff;
      side2_in.dz      = (op1_ff == OP_DIV) && (b1_ff == 32'sd0);
      side2_in.neg     = a1_ff[31] ^ b1_ff[31];
      // Twice the scaled numerator, so the chain yields floor(2a/b) for rounding.
      nq2_in = {mag_a, {(FRAC_BITS + 1){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      side2_ff <= side2_in;
      p2_ff    <= a1_ff * b1_ff;
      nq2_ff   <= nq2_in;
      den2_ff  <= mag_b;
   end

   always_comb begin
      mag_p = p2_ff[63] ? -p2_ff : p2_ff;
      mul_m = (mag_p + RND) >> FRAC_BITS;
      mul_r = sign_mag(p2_ff[63], mul_m);
      cside[0] = side2_ff;
      if (side2_ff.op == OP_MUL) begin
         cside[0].result = mul_r.result;
         cside[0].ov     = mul_r.ov;
      end
      cv[0]   = v2_ff;
      cnq[0]  = nq2_ff;
      crem[0] = 32'd0;
      cden[0] = den2_ff;
   end

   for (genvar i = 0; i < NW; i++) begin : g_cell
      fap_cell #(.NW(NW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .valid_in (cv[i]),
         .side_in  (cside[i]),
         .nq_in    (cnq[i]),
         .rem_in   (crem[i]),
         .den_in   (cden[i]),
         .valid_out(cv[i+1]),
         .side_out (cside[i+1]),
         .nq_out   (cnq[i+1]),
         .rem_out  (crem[i+1]),
         .den_out  (cden[i+1])
      );
   end

   always_comb begin
      q_round = ({1'b0, cnq[NW]} + {{NW{1'b0}}, 1'b1}) >> 1;
      div_r   = sign_mag(cside[NW].neg, 64'(q_round));
      fin_result = cside[NW].result;
      fin_ov     = cside[NW].ov;
      if (cside[NW].op == OP_DIV) begin
         fin_result = cside[NW].dz ? 32'd0 : div_r.result;
         fin_ov     = cside[NW].dz ? 1'b0 : div_r.ov;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cv[NW];
      end
      rsp_result_ff  <= fin_result;
      rsp_ov_ff      <= fin_ov;
      rsp_dz_ff      <= cside[NW].dz;
      rsp_less_ff    <= cside[NW].less;
      rsp_equal_ff   <= cside[NW].equal;
      rsp_greater_ff <= cside[NW].greater;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result      = rsp_result_ff;
   assign rsp_a_less      = rsp_less_ff;
   assign rsp_a_equal     = rsp_equal_ff;
   assign rsp_a_greater   = rsp_greater_ff;
   assign rsp_overflow    = rsp_ov_ff;
   assign rsp_div_by_zero = rsp_dz_ff;

   `AST_PROP(a_flags_onehot, clock, reset, rsp_valid |-> $onehot({rsp_a_less, rsp_a_equal, rsp_a_greater}))
   `AST_NEVER(a_dz_and_ov, clock, reset, rsp_valid && rsp_div_by_zero && rsp_overflow)
   `AST_PROP(a_dz_zero, clock, reset, (rsp_valid && rsp_div_by_zero) |-> (rsp_result == 32'sd0))
   `AST_PROP(a_latency, clock, reset, (start && !busy) |-> ##LAT rsp_valid)

endmodule
`default_nettype wire

>>> sv/fap_cell.sv
`default_nettype none
// One restoring-division step: brings down one numerator bit, yields one quotient bit.
module fap_cell
   import fap_pkg::*;
#(
   parameter int NW = 41
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          valid_in,
   input  wire side_type      side_in,
   input  wire logic [NW-1:0] nq_in,
   input  wire logic [31:0]   rem_in,
   input  wire logic [31:0]   den_in,
   output logic               valid_out,
   output side_type           side_out,
   output logic [NW-1:0]      nq_out,
   output logic [31:0]        rem_out,
   output logic [31:0]        den_out
);

   logic            valid_ff;
   side_type        side_ff;
   logic [NW-1:0]   nq_ff, nq_in_v;
   logic [31:0]     rem_ff, rem_in_v, den_ff;
   logic [32:0]     shifted;
   logic [33:0]     diff;
   logic            qbit;

   always_comb begin
      shifted  = {rem_in, nq_in[NW-1]};
      diff     = {1'b0, shifted} - {2'b00, den_in};
      qbit     = ~diff[33];
      rem_in_v = qbit ? diff[31:0] : shifted[31:0];
      nq_in_v  = {nq_in[NW-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      side_ff <= side_in;
      nq_ff   <= nq_in_v;
      rem_ff  <= rem_in_v;
      den_ff  <= den_in;
   end

   assign valid_out = valid_ff;
   assign side_out  = side_ff;
   assign nq_out    = nq_ff;
   assign rem_out   = rem_ff;
   assign den_out   = den_ff;

endmodule
`default_nettype wire
